// File: rtl/core/crcd_pkg.sv
// Shared types, constants and the CRC-32 byte step for the record deframer.
package crcd_pkg;

  // Default width of the record byte counter.
  localparam int LenBitsDefault = 32;

  // Number of result requests held between the front and back parts.
  localparam int QueueDepth = 4;

  // Header layout: checksum, flags, key length, value length.
  localparam int HeaderBytes = 13;

  // Reflected CRC-32 polynomial.
  localparam logic [31:0] CrcPoly = 32'hEDB88320;

  // Flags byte mask that marks a tombstone record.
  localparam logic [7:0] TombstoneMask = 8'h01;

  // End-of-record status codes.
  typedef enum logic [1:0] {
    StOk        = 2'd0,
    StTruncated = 2'd1,
    StCrcBad    = 2'd2,
    StLenBad    = 2'd3
  } status_e;

  // One request from the front part: an optional payload byte and an
  // optional status, both caused by the same input byte.
  typedef struct packed {
    logic [7:0]  data;
    logic        has_payload;
    logic        in_value;
    logic        has_status;
    logic        tombstone;
    status_e     status;
    logic [31:0] key_length;
    logic [31:0] value_length;
  } result_req_t;

  // Advance a reflected CRC-32 register by one byte.
  function automatic logic [31:0] crc_byte(logic [31:0] crc, logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'd0, b};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CrcPoly) : (c >> 1);
    end
    return c;
  endfunction

endpackage

// File: rtl/core/crcd_front.sv
// Front part: accepts record bytes, tracks the header and CRC, classifies each byte.
module crcd_front import crcd_pkg::*; #(
  parameter int LenBits = LenBitsDefault
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [7:0]        in_byte_i,
  input  logic              record_end_i,
  output logic              req_valid_o,
  output result_req_t       req_o,
  input  logic              req_ready_i
);

  localparam logic [LenBits-1:0] PosMax     = '1;
  localparam logic [LenBits-1:0] PosFlags   = LenBits'(4);
  localparam logic [LenBits-1:0] PosKeyEnd  = LenBits'(9);
  localparam logic [LenBits-1:0] PosHdrLast = LenBits'(HeaderBytes - 1);
  localparam logic [LenBits-1:0] PosHdrEnd  = LenBits'(HeaderBytes);

  logic [LenBits-1:0] pos_q, pos_d;
  logic [31:0]        stored_crc_q, stored_crc_d;
  logic [31:0]        crc_q, crc_d;
  logic               tomb_q, tomb_d;
  logic [31:0]        klen_q, klen_d;
  logic [31:0]        vlen_q, vlen_d;
  logic [32:0]        lsum_q, lsum_d;

  logic               accept;
  logic               saturated;
  logic [1:0]         lane;
  logic [31:0]        byte_shifted;
  logic [LenBits-1:0] offset;
  logic [32:0]        offset_x;
  logic               is_key;
  logic               is_val;
  logic [32:0]        expect_m;
  logic               len_ok;
  logic               trunc;
  logic               crc_bad;
  status_e            code;

  assign accept     = in_valid_i && req_ready_i;
  assign in_ready_o = req_ready_i;
  assign saturated  = (pos_q == PosMax);

  // Header assembly, CRC update and position count.
  always_comb begin
    pos_d        = pos_q;
    stored_crc_d = stored_crc_q;
    crc_d        = crc_q;
    tomb_d       = tomb_q;
    klen_d       = klen_q;
    vlen_d       = vlen_q;

    // Length bytes sit at positions 5..8 and 9..12, checksum at 0..3.
    lane         = (pos_q < PosFlags) ? pos_q[1:0] : (pos_q[1:0] - 2'd1);
    byte_shifted = {24'd0, in_byte_i} << {lane, 3'b000};

    if (pos_q < PosFlags) begin
      stored_crc_d = stored_crc_q | byte_shifted;
    end else begin
      crc_d = crc_byte(crc_q, in_byte_i);
      if (pos_q == PosFlags) begin
        tomb_d = (in_byte_i & TombstoneMask) != 8'd0;
      end else if (pos_q < PosKeyEnd) begin
        klen_d = klen_q | byte_shifted;
      end else if (pos_q < PosHdrEnd) begin
        vlen_d = vlen_q | byte_shifted;
      end
    end

    lsum_d = {1'b0, klen_d} + {1'b0, vlen_d};
    pos_d  = saturated ? pos_q : (pos_q + LenBits'(1));

    // Payload classification against the finished header.
    offset   = pos_q - PosHdrEnd;
    offset_x = 33'(offset);
    is_key   = (pos_q >= PosHdrEnd) && !saturated && (offset_x < {1'b0, klen_q});
    is_val   = (pos_q >= PosHdrEnd) && !saturated && !is_key && !tomb_q
               && (offset_x < lsum_q);

    // End-of-record checks, in priority order.
    expect_m = tomb_d ? {1'b0, klen_d} : lsum_d;
    len_ok   = (34'(pos_q) == (34'(expect_m) + 34'(HeaderBytes - 1)));
    trunc    = pos_q < PosHdrLast;
    crc_bad  = (~crc_d) != stored_crc_d;
    if (trunc) begin
      code = StTruncated;
    end else if (crc_bad) begin
      code = StCrcBad;
    end else if (saturated || !len_ok) begin
      code = StLenBad;
    end else begin
      code = StOk;
    end

    // Request toward the back part.
    req_o.data         = in_byte_i;
    req_o.has_payload  = is_key || is_val;
    req_o.in_value     = is_val;
    req_o.has_status   = record_end_i;
    req_o.tombstone    = tomb_d;
    req_o.status       = code;
    req_o.key_length   = klen_d;
    req_o.value_length = tomb_d ? 32'd0 : vlen_d;
    req_valid_o        = accept && (is_key || is_val || record_end_i);

    // The last byte of a record returns all state to reset.
    if (record_end_i) begin
      pos_d        = '0;
      stored_crc_d = '0;
      crc_d        = '1;
      tomb_d       = 1'b0;
      klen_d       = '0;
      vlen_d       = '0;
      lsum_d       = '0;
    end
  end

  // Record state registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q        <= '0;
      stored_crc_q <= '0;
      crc_q        <= '1;
      tomb_q       <= 1'b0;
      klen_q       <= '0;
      vlen_q       <= '0;
      lsum_q       <= '0;
    end else if (accept) begin
      pos_q        <= pos_d;
      stored_crc_q <= stored_crc_d;
      crc_q        <= crc_d;
      tomb_q       <= tomb_d;
      klen_q       <= klen_d;
      vlen_q       <= vlen_d;
      lsum_q       <= lsum_d;
    end
  end

endmodule

// File: rtl/core/crcd_fifo.sv
// Short request queue between the front and back parts.
module crcd_fifo import crcd_pkg::*; #(
  parameter int Depth = QueueDepth
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push_i,
  input  result_req_t data_i,
  output logic        ready_o,
  input  logic        pop_i,
  output logic        valid_o,
  output result_req_t data_o
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] CntFull = CntW'(Depth);

  result_req_t         mem_q [Depth];
  logic [PtrW-1:0]     wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]     rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]     count_q, count_d;

  assign ready_o = (count_q != CntFull);
  assign valid_o = (count_q != '0);
  assign data_o  = mem_q[rd_ptr_q];

  // Pointer and fill count update.
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrLast) ? '0 : (wr_ptr_q + PtrW'(1));
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrLast) ? '0 : (rd_ptr_q + PtrW'(1));
    end
    if (push_i && !pop_i) begin
      count_d = count_q + CntW'(1);
    end else if (!push_i && pop_i) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Storage, written at the tail.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  // The fill count never passes the depth.
  assert property (@(posedge clk_i) disable iff (!rst_ni) count_q <= CntFull)
    else $error("request queue overfilled");

  // A lone push grows the count by exactly one.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i && !pop_i) |=> (count_q == $past(count_q) + CntW'(1)))
    else $error("request queue count lost a push");

endmodule

// File: rtl/core/crcd_back.sv
// Back part: expands queued requests into payload and status results.
module crcd_back import crcd_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        req_valid_i,
  input  result_req_t req_i,
  output logic        req_pop_o,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [7:0]  out_byte_o,
  output logic        is_status_o,
  output logic        in_value_o,
  output logic        is_tombstone_o,
  output logic [1:0]  status_o,
  output logic [31:0] key_length_o,
  output logic [31:0] value_length_o,
  output logic        last_o
);

  typedef enum logic {
    PhFirst,
    PhStatus
  } phase_e;

  phase_e      phase_q, phase_d;
  logic        out_valid_q, out_valid_d;
  logic [7:0]  byte_q, byte_d;
  logic        is_status_q, is_status_d;
  logic        in_value_q, in_value_d;
  logic        tomb_q, tomb_d;
  status_e     status_q, status_d;
  logic [31:0] klen_q, klen_d;
  logic [31:0] vlen_q, vlen_d;
  logic        last_q, last_d;
  logic        load;
  logic        emit;

  // Output register loads when empty or when its result is taken.
  always_comb begin
    load        = !out_valid_q || out_ready_i;
    emit        = load && req_valid_i;
    phase_d     = phase_q;
    req_pop_o   = 1'b0;
    out_valid_d = out_valid_q && !out_ready_i;
    byte_d      = byte_q;
    is_status_d = is_status_q;
    in_value_d  = in_value_q;
    tomb_d      = tomb_q;
    status_d    = status_q;
    klen_d      = klen_q;
    vlen_d      = vlen_q;
    last_d      = last_q;
    if (emit) begin
      out_valid_d = 1'b1;
      if (req_i.has_payload && (phase_q == PhFirst)) begin
        // Payload byte first; a pending status follows next.
        byte_d      = req_i.data;
        is_status_d = 1'b0;
        in_value_d  = req_i.in_value;
        tomb_d      = 1'b0;
        status_d    = StOk;
        klen_d      = '0;
        vlen_d      = '0;
        last_d      = !req_i.has_status;
        if (req_i.has_status) begin
          phase_d = PhStatus;
        end else begin
          req_pop_o = 1'b1;
        end
      end else begin
        byte_d      = '0;
        is_status_d = 1'b1;
        in_value_d  = 1'b0;
        tomb_d      = req_i.tombstone;
        status_d    = req_i.status;
        klen_d      = req_i.key_length;
        vlen_d      = req_i.value_length;
        last_d      = 1'b1;
        req_pop_o   = 1'b1;
        phase_d     = PhFirst;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PhFirst;
      out_valid_q <= 1'b0;
      byte_q      <= '0;
      is_status_q <= 1'b0;
      in_value_q  <= 1'b0;
      tomb_q      <= 1'b0;
      status_q    <= StOk;
      klen_q      <= '0;
      vlen_q      <= '0;
      last_q      <= 1'b0;
    end else begin
      phase_q     <= phase_d;
      out_valid_q <= out_valid_d;
      byte_q      <= byte_d;
      is_status_q <= is_status_d;
      in_value_q  <= in_value_d;
      tomb_q      <= tomb_d;
      status_q    <= status_d;
      klen_q      <= klen_d;
      vlen_q      <= vlen_d;
      last_q      <= last_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign out_byte_o     = byte_q;
  assign is_status_o    = is_status_q;
  assign in_value_o     = in_value_q;
  assign is_tombstone_o = tomb_q;
  assign status_o       = status_q;
  assign key_length_o   = klen_q;
  assign value_length_o = vlen_q;
  assign last_o         = last_q;

  // While a status is pending, the head request still holds it.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PhStatus) |-> (req_valid_i && req_i.has_status))
    else $error("pending status lost its request");

  // A status result always closes the results of its byte.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && is_status_q) |-> last_q)
    else $error("status result not marked last");

endmodule

// File: rtl/core/crc_checked_record_deframer.sv
// Top level of the CRC-checked record deframer.
// Takes a log record one byte per cycle while the request queue has room and passes each key or
// value byte out as it arrives; the record's last byte also yields a status result (ok,
// truncated, checksum mismatch, length mismatch) with the header fields. The front part carries
// the CRC-32 byte step and the position counter; a last byte that also carries payload gives two
// results, and the back part's output register delivers one result per cycle while the consumer
// takes them, with a four-entry request queue between the two parts. The first result of a byte
// is written into the request queue and then loaded into the output register. Payload bytes
// leave before the status, so a consumer must discard them when the status is not ok. No reset
// pass is needed; the block is ready as soon as reset is released.
module crc_checked_record_deframer import crcd_pkg::*; #(
  parameter int LENGTH_BITS = LenBitsDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  in_byte_i,
  input  logic        record_end_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [7:0]  out_byte_o,
  output logic        is_status_o,
  output logic        in_value_o,
  output logic        is_tombstone_o,
  output logic [1:0]  status_o,
  output logic [31:0] key_length_o,
  output logic [31:0] value_length_o,
  output logic        last_o
);

  logic        push;
  result_req_t push_req;
  logic        q_ready;
  logic        q_valid;
  logic        pop;
  result_req_t head_req;

  // Front part: header, CRC and byte classification.
  crcd_front #(
    .LenBits(LENGTH_BITS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_byte_i   (in_byte_i),
    .record_end_i(record_end_i),
    .req_valid_o (push),
    .req_o       (push_req),
    .req_ready_i (q_ready)
  );

  // Request queue.
  crcd_fifo #(
    .Depth(QueueDepth)
  ) u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .data_i (push_req),
    .ready_o(q_ready),
    .pop_i  (pop),
    .valid_o(q_valid),
    .data_o (head_req)
  );

  // Back part: result sequencing and output register.
  crcd_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .req_valid_i   (q_valid),
    .req_i         (head_req),
    .req_pop_o     (pop),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .out_byte_o    (out_byte_o),
    .is_status_o   (is_status_o),
    .in_value_o    (in_value_o),
    .is_tombstone_o(is_tombstone_o),
    .status_o      (status_o),
    .key_length_o  (key_length_o),
    .value_length_o(value_length_o),
    .last_o        (last_o)
  );

endmodule

// File: tb/tb_crc_checked_record_deframer.sv
// Self-checking testbench for the CRC-checked record deframer.
`timescale 1ns / 100ps

module tb_crc_checked_record_deframer import crcd_pkg::*; ();

  // A byte counter narrower than the default.
  localparam int LenBits = 16;
  localparam longint unsigned PosMax = (64'd1 << LenBits) - 1;
  localparam int RandItems = 700;
  localparam int StallLimit = 1000;
  localparam int DrainCycles = 20;
  localparam int IdlePct = 18;

  // One expected result, laid out in port order.
  typedef struct packed {
    logic [7:0]  ob;
    logic        st;
    logic        iv;
    logic        tb;
    logic [1:0]  code;
    logic [31:0] kl;
    logic [31:0] vl;
    logic        last;
  } deframe_out_t;

  // Description of one record to send.
  typedef struct {
    logic [7:0]  flags;
    logic [31:0] klen;
    logic [31:0] vlen;
    int          body;
    bit          crc_good;
    int          cut;
    bit          fixed;
    logic [7:0]  fill;
    bit          typed;
    status_e     want;
  } rec_spec_t;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_ready_o;
  logic [7:0]  in_byte_i;
  logic        record_end_i;
  logic        out_valid_o;
  logic        out_ready_i;
  logic [7:0]  out_byte_o;
  logic        is_status_o;
  logic        in_value_o;
  logic        is_tombstone_o;
  logic [1:0]  status_o;
  logic [31:0] key_length_o;
  logic [31:0] value_length_o;
  logic        last_o;

  // Predicted header state of the record in flight.
  longint unsigned rec_pos;
  logic [31:0]     rec_sum;
  logic [31:0]     rec_crc;
  logic            rec_tomb;
  logic [31:0]     rec_klen;
  logic [31:0]     rec_vlen;

  deframe_out_t pending_results[$];
  bit           code_typed;
  status_e      code_want;
  bit           idle_on;
  int           err_cnt;
  int           sent_cnt;
  int           rec_cnt;
  int           res_cnt;
  int           quiet_cycles;
  int           code_seen[4];

  crc_checked_record_deframer #(
    .LENGTH_BITS(LenBits)
  ) i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .in_byte_i      (in_byte_i),
    .record_end_i   (record_end_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .out_byte_o     (out_byte_o),
    .is_status_o    (is_status_o),
    .in_value_o     (in_value_o),
    .is_tombstone_o (is_tombstone_o),
    .status_o       (status_o),
    .key_length_o   (key_length_o),
    .value_length_o (value_length_o),
    .last_o         (last_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Reflected CRC-32, one data bit per step.
  function automatic logic [31:0] crc32_step(logic [31:0] c, logic [7:0] b);
    logic fb;
    for (int i = 0; i < 8; i++) begin
      fb = c[0] ^ b[i];
      c = c >> 1;
      if (fb) c = c ^ CrcPoly;
    end
    return c;
  endfunction

  task automatic clear_record_state();
    rec_pos  = 0;
    rec_sum  = '0;
    rec_crc  = '1;
    rec_tomb = 1'b0;
    rec_klen = '0;
    rec_vlen = '0;
  endtask

  // Work out the results one accepted byte causes and queue them.
  task automatic predict_record_byte(input logic [7:0] b, input logic fin);
    deframe_out_t    res [2];
    int              n;
    int              idx;
    logic            sat;
    longint unsigned p;
    longint unsigned off;
    logic [31:0]     vrep;
    status_e         code;
    n = 0;
    p = rec_pos;
    sat = (p >= PosMax);
    idx = int'(p);
    if (p < 4) begin
      rec_sum[8*idx +: 8] = b;
    end else begin
      rec_crc = crc32_step(rec_crc, b);
      if (p == 4) begin
        rec_tomb = b[0];
      end else if (p < 9) begin
        rec_klen[8*(idx-5) +: 8] = b;
      end else if (p < HeaderBytes) begin
        rec_vlen[8*(idx-9) +: 8] = b;
      end else if (!sat) begin
        // Key bytes first, then value bytes; anything past both is dropped.
        off = p - HeaderBytes;
        if (off < rec_klen) begin
          res[n] = '0;
          res[n].ob = b;
          n++;
        end else if (!rec_tomb && (off - rec_klen) < rec_vlen) begin
          res[n] = '0;
          res[n].ob = b;
          res[n].iv = 1'b1;
          n++;
        end
      end
    end
    if (!sat) rec_pos = p + 1;
    if (fin) begin
      vrep = rec_tomb ? 32'd0 : rec_vlen;
      if (p < HeaderBytes - 1) code = StTruncated;
      else if (~rec_crc != rec_sum) code = StCrcBad;
      else if (sat || p + 1 != longint'(HeaderBytes) + rec_klen + vrep) code = StLenBad;
      else code = StOk;
      if (code_typed) begin
        code = code_want;
        code_typed = 1'b0;
      end
      res[n] = '0;
      res[n].st = 1'b1;
      res[n].tb = rec_tomb;
      res[n].code = code;
      res[n].kl = rec_klen;
      res[n].vl = vrep;
      n++;
      clear_record_state();
    end
    if (n > 0) begin
      res[n-1].last = 1'b1;
      for (int i = 0; i < n; i++) pending_results = {pending_results, res[i]};
    end
  endtask

  task automatic check_field(input string name, input logic [31:0] exp_v,
                             input logic [31:0] act_v);
    if (act_v !== exp_v) begin
      err_cnt++;
      $display("%0t: %s expected %0h, got %0h", $time, name, exp_v, act_v);
    end
  endtask

  // Offer one byte at a falling edge, with random idle cycles first.
  task automatic send_byte(input logic [7:0] b, input logic fin);
    while (idle_on && $urandom_range(0, 99) < IdlePct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i   <= 1'b1;
    in_byte_i    <= b;
    record_end_i <= fin;
    do @(posedge clk_i); while (!in_ready_o);
    @(negedge clk_i);
    sent_cnt++;
  endtask

  // Build a record with its checksum over the bytes actually sent.
  task automatic drive_record(input rec_spec_t s);
    logic [7:0]  rec[$];
    logic [31:0] sum;
    int          n;
    rec = {};
    repeat (4) rec = {rec, 8'h00};
    rec = {rec, s.flags};
    for (int i = 0; i < 4; i++) rec = {rec, s.klen[8*i +: 8]};
    for (int i = 0; i < 4; i++) rec = {rec, s.vlen[8*i +: 8]};
    repeat (s.body) rec = {rec, (s.fixed ? s.fill : 8'($urandom))};
    n = (s.cut != 0 && s.cut < rec.size()) ? s.cut : rec.size();
    sum = '1;
    for (int i = 4; i < n; i++) sum = crc32_step(sum, rec[i]);
    sum = ~sum;
    if (!s.crc_good) sum ^= 32'd1 << $urandom_range(0, 31);
    for (int i = 0; i < 4 && i < n; i++) rec[i] = sum[8*i +: 8];
    code_typed = s.typed;
    code_want = s.want;
    for (int i = 0; i < n; i++) send_byte(rec[i], i == n - 1);
    rec_cnt++;
  endtask

  function automatic rec_spec_t mk_row(logic [7:0] flags, logic [31:0] klen,
                                       logic [31:0] vlen, int body, bit crc_good,
                                       int cut, bit fixed, logic [7:0] fill,
                                       bit typed, status_e want);
    rec_spec_t s;
    s.flags = flags;
    s.klen = klen;
    s.vlen = vlen;
    s.body = body;
    s.crc_good = crc_good;
    s.cut = cut;
    s.fixed = fixed;
    s.fill = fill;
    s.typed = typed;
    s.want = want;
    return s;
  endfunction

  // Accepted input requests feed the predictor.
  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && in_ready_o) predict_record_byte(in_byte_i, record_end_i);
  end

  // Each accepted result request is compared with the oldest expectation.
  always @(posedge clk_i) begin : result_check
    deframe_out_t got_res;
    deframe_out_t exp_res;
    if (rst_ni && out_valid_o && out_ready_i) begin
      got_res = {out_byte_o, is_status_o, in_value_o, is_tombstone_o, status_o,
                 key_length_o, value_length_o, last_o};
      if (pending_results.size() == 0) begin
        err_cnt++;
        $display("%0t: unexpected result, expected none, got %h", $time, got_res);
      end else begin
        exp_res = pending_results.pop_front();
        check_field("out_byte", exp_res.ob, got_res.ob);
        check_field("is_status", exp_res.st, got_res.st);
        check_field("in_value", exp_res.iv, got_res.iv);
        check_field("is_tombstone", exp_res.tb, got_res.tb);
        check_field("status", exp_res.code, got_res.code);
        check_field("key_length", exp_res.kl, got_res.kl);
        check_field("value_length", exp_res.vl, got_res.vl);
        check_field("last", exp_res.last, got_res.last);
      end
      if (got_res.st === 1'b1) code_seen[got_res.code]++;
      res_cnt++;
    end
  end

  // Random back pressure on the result side.
  always @(negedge clk_i) begin
    out_ready_i <= !idle_on || ($urandom_range(0, 99) >= IdlePct);
  end

  // Watchdog on cycles without any accepted request.
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= StallLimit) begin
      $display("%0t: no request accepted for %0d cycles", $time, StallLimit);
      $display("end of test: mismatches");
      $finish;
    end
  end

  // Stimulus: directed records, then random records and noise.
  initial begin : stimulus
    rec_spec_t dir_tab[14];
    rec_spec_t s;
    int        pick;
    int        exact;
    int        tmp;
    int        nz;
    int        rand_base;
    rst_ni       = 1'b0;
    in_valid_i   = 1'b0;
    in_byte_i    = 8'h00;
    record_end_i = 1'b0;
    idle_on      = 1'b1;
    code_typed   = 1'b0;
    code_want    = StOk;
    err_cnt      = 0;
    sent_cnt     = 0;
    rec_cnt      = 0;
    res_cnt      = 0;
    quiet_cycles = 0;
    for (int i = 0; i < 4; i++) code_seen[i] = 0;
    clear_record_state();
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // flags, key len, value len, body bytes, good crc, cut, fixed fill, fill, typed, status
    dir_tab[0]  = mk_row(8'h00, 32'd3, 32'd4, 7, 1, 0, 1, 8'h00, 1, StOk);
    dir_tab[1]  = mk_row(8'h00, 32'd0, 32'd0, 0, 1, 0, 0, 8'h00, 1, StOk);
    dir_tab[2]  = mk_row(8'h01, 32'd2, 32'd5, 2, 1, 0, 0, 8'h00, 1, StOk);
    dir_tab[3]  = mk_row(8'h01, 32'd2, 32'd5, 7, 1, 0, 0, 8'h00, 1, StLenBad);
    dir_tab[4]  = mk_row(8'h00, 32'd2, 32'd2, 4, 0, 0, 0, 8'h00, 1, StCrcBad);
    dir_tab[5]  = mk_row(8'h00, 32'd0, 32'd0, 0, 1, 1, 0, 8'h00, 1, StTruncated);
    dir_tab[6]  = mk_row(8'h00, 32'd1, 32'd1, 2, 1, 12, 0, 8'h00, 1, StTruncated);
    dir_tab[7]  = mk_row(8'h00, 32'd1, 32'd1, 5, 1, 0, 0, 8'h00, 0, StOk);
    dir_tab[8]  = mk_row(8'h00, 32'd4, 32'd4, 3, 1, 0, 0, 8'h00, 0, StOk);
    dir_tab[9]  = mk_row(8'h00, 32'd1, 32'd1, 5, 0, 0, 0, 8'h00, 1, StCrcBad);
    dir_tab[10] = mk_row(8'h00, 32'd1, 32'd1, 2, 0, 7, 0, 8'h00, 1, StTruncated);
    dir_tab[11] = mk_row(8'hFF, '1, '1, 6, 1, 0, 0, 8'h00, 1, StLenBad);
    dir_tab[12] = mk_row(8'hFE, 32'd0, '1, 4, 1, 0, 0, 8'h00, 1, StLenBad);
    dir_tab[13] = mk_row(8'h00, 32'd0, 32'd3, 3, 1, 0, 1, 8'hFF, 0, StOk);
    foreach (dir_tab[i]) drive_record(dir_tab[i]);

    // Random records: mostly well formed, some broken, some raw noise.
    rand_base = sent_cnt;
    while (sent_cnt < rand_base + RandItems) begin
      idle_on = !((sent_cnt - rand_base) >= 250 && (sent_cnt - rand_base) < 500);
      pick = $urandom_range(0, 99);
      if (pick >= 92) begin
        nz = $urandom_range(1, 20);
        for (int j = 0; j < nz; j++)
          send_byte(8'($urandom), (j == nz - 1) || ($urandom_range(0, 5) == 0));
      end else begin
        s = mk_row(8'($urandom), $urandom_range(0, 8), $urandom_range(0, 8), 0,
                   1, 0, 0, 8'h00, 0, StOk);
        exact = int'(s.klen) + (s.flags[0] ? 0 : int'(s.vlen));
        s.body = exact;
        if (pick >= 65 && pick < 75) begin
          s.crc_good = 0;
        end else if (pick >= 75 && pick < 85) begin
          if ($urandom_range(0, 3) == 0) begin
            s.klen = $urandom;
            s.vlen = $urandom;
            s.body = $urandom_range(0, 6);
          end else begin
            tmp = exact + int'($urandom_range(0, 6)) - 3;
            s.body = (tmp < 0) ? 0 : tmp;
          end
        end else if (pick >= 85) begin
          s.cut = $urandom_range(1, 12);
        end
        drive_record(s);
      end
    end
    in_valid_i <= 1'b0;
    idle_on = 1'b1;

    // Drain, then allow a few more cycles for stray results.
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    $display("Run covered %0d bytes in %0d directed and random records, %0d results checked.",
             sent_cnt, rec_cnt, res_cnt);
    $display("Status results seen: %0d ok, %0d truncated, %0d checksum bad, %0d length bad.",
             code_seen[StOk], code_seen[StTruncated], code_seen[StCrcBad],
             code_seen[StLenBad]);
    if (err_cnt == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
